// File: hdl/htcc_pkg.sv
// Package: shared types and constants for the HSI traffic color classifier.
package htcc_pkg;
    localparam int CORDIC_STEPS = 16;
    localparam int XW = 28;
    localparam int SQRT3_Q16 = 113512;
    localparam int NUM_REGS = 8;

    typedef logic signed [XW-1:0] t_vec;

    typedef enum logic [1:0] {
        CLS_RED    = 2'd0,
        CLS_YELLOW = 2'd1,
        CLS_GREEN  = 2'd2,
        CLS_NONE   = 2'd3
    } t_class;

    typedef enum logic [2:0] {
        REG_RED_SAT    = 3'd0,
        REG_RED_INT    = 3'd1,
        REG_YEL_SAT    = 3'd2,
        REG_YEL_INT    = 3'd3,
        REG_GRN_SAT    = 3'd4,
        REG_GRN_INT    = 3'd5,
        REG_GRN_HUE_HI = 3'd6,
        REG_SELECT     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [6:0] red_sat;
        logic [6:0] red_int;
        logic [6:0] yel_sat;
        logic [6:0] yel_int;
        logic [6:0] grn_sat;
        logic [6:0] grn_int;
        logic [6:0] grn_hue_hi;
        logic [1:0] sel;
    } t_cfg;

    // per-pixel side data carried alongside the hue pipeline
    typedef struct packed {
        logic [9:0] sum;
        logic [9:0] chroma;
    } t_side;

    function automatic logic [15:0] atan_q16(input logic [3:0] i);
        case (i)
            4'd0:    atan_q16 = 16'd8192;
            4'd1:    atan_q16 = 16'd4836;
            4'd2:    atan_q16 = 16'd2555;
            4'd3:    atan_q16 = 16'd1297;
            4'd4:    atan_q16 = 16'd651;
            4'd5:    atan_q16 = 16'd326;
            4'd6:    atan_q16 = 16'd163;
            4'd7:    atan_q16 = 16'd81;
            4'd8:    atan_q16 = 16'd41;
            4'd9:    atan_q16 = 16'd20;
            4'd10:   atan_q16 = 16'd10;
            4'd11:   atan_q16 = 16'd5;
            4'd12:   atan_q16 = 16'd3;
            4'd13:   atan_q16 = 16'd1;
            4'd14:   atan_q16 = 16'd1;
            default: atan_q16 = 16'd0;
        endcase
    endfunction
endpackage

// File: hdl/htcc_pix_if.sv
// Interfaces: pixel request channel and class result channel.
interface htcc_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

interface htcc_cls_if;
    logic       valid;
    logic       ready;
    logic [1:0] color_class;
    logic [7:0] mask_value;
    modport source (output valid, color_class, mask_value, input ready);
    modport sink   (input valid, color_class, mask_value, output ready);
endinterface

// File: hdl/htcc_cordic_stage.sv
// One CORDIC vectoring iteration with pipeline register.
module htcc_cordic_stage
    import htcc_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_vec        i_x,
    input  t_vec        i_y,
    input  logic [15:0] i_z,
    input  t_side       i_side,
    output logic        o_valid,
    output t_vec        o_x,
    output t_vec        o_y,
    output logic [15:0] o_z,
    output t_side       o_side
);
    localparam logic [15:0] ANG = atan_q16(4'(STEP));
    t_vec xs, ys;
    assign xs = i_x >>> STEP;
    assign ys = i_y >>> STEP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side <= i_side;
            if (i_y > 0) begin
                o_x <= i_x + ys;
                o_y <= i_y - xs;
                o_z <= i_z + ANG;
            end else begin
                o_x <= i_x - ys;
                o_y <= i_y + xs;
                o_z <= i_z - ANG;
            end
        end
    end
endmodule

// File: hdl/htcc_classify.sv
// Classification stages: threshold products, then class and mask.
module htcc_classify
    import htcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [15:0] i_hue,
    input  t_side       i_side,
    input  t_cfg        i_cfg,
    output logic        o_valid,
    output logic [1:0]  o_class,
    output logic [7:0]  o_mask
);
    logic        r_valid;
    logic [5:0]  r_pass;
    logic [2:0]  r_hue_ok;
    logic [1:0]  r_sel;
    logic [16:0] c100, s100;
    logic [22:0] h100;
    logic [5:0]  n_pass;
    logic [2:0]  n_hue_ok;
    t_class      cls;

    assign c100 = 17'(i_side.chroma) * 17'd100;
    assign s100 = 17'(i_side.sum) * 17'd100;
    assign h100 = 23'(i_hue) * 23'd100;

    always_comb begin
        n_pass[0] = c100 > 17'(i_cfg.red_sat) * 17'(i_side.sum);
        n_pass[1] = s100 > 17'(i_cfg.red_int) * 17'd765;
        n_pass[2] = c100 > 17'(i_cfg.yel_sat) * 17'(i_side.sum);
        n_pass[3] = s100 > 17'(i_cfg.yel_int) * 17'd765;
        n_pass[4] = c100 > 17'(i_cfg.grn_sat) * 17'(i_side.sum);
        n_pass[5] = s100 > 17'(i_cfg.grn_int) * 17'd765;
        n_hue_ok[0] = (h100 >= 23'd90 * 23'd65536) || (h100 <= 23'd7 * 23'd65536);
        n_hue_ok[1] = (h100 >= 23'd7 * 23'd65536) && (h100 <= 23'd15 * 23'd65536);
        n_hue_ok[2] = (h100 >= 23'd40 * 23'd65536)
                   && (h100 <= 23'(i_cfg.grn_hue_hi) * 23'd65536);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
            o_valid <= r_valid;
        end
    end

    always_comb begin
        if (r_hue_ok[0] && r_pass[0] && r_pass[1]) begin
            cls = CLS_RED;
        end else if (r_hue_ok[1] && r_pass[2] && r_pass[3]) begin
            cls = CLS_YELLOW;
        end else if (r_hue_ok[2] && r_pass[4] && r_pass[5]) begin
            cls = CLS_GREEN;
        end else begin
            cls = CLS_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pass   <= n_pass;
            r_hue_ok <= n_hue_ok;
            r_sel    <= i_cfg.sel;
            o_class  <= cls;
            o_mask   <= (cls == r_sel) ? 8'd255 : 8'd0;
        end
    end
endmodule

// File: hdl/hsi_traffic_color_classifier.sv
// Top level: RGB to HSI traffic light color classifier.
// Path: stage 0 register, the CORDIC stages, threshold register, then output register.
// Throughput: one pixel per cycle while results are taken; a 16-step CORDIC pipeline sets the depth.
// The whole pipeline holds when the output register is full and not taken.
// Reset: synchronous active-low; clears valid bits and loads register defaults.
module hsi_traffic_color_classifier
    import htcc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    htcc_pix_if.sink   pix,
    htcc_cls_if.source cls,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [6:0] i_cfg_data
);
    t_cfg r_cfg;
    logic en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{7'd27, 7'd19, 7'd35, 7'd35, 7'd24, 7'd11, 7'd55, 2'd0};
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_RED_SAT:    r_cfg.red_sat    <= i_cfg_data;
                REG_RED_INT:    r_cfg.red_int    <= i_cfg_data;
                REG_YEL_SAT:    r_cfg.yel_sat    <= i_cfg_data;
                REG_YEL_INT:    r_cfg.yel_int    <= i_cfg_data;
                REG_GRN_SAT:    r_cfg.grn_sat    <= i_cfg_data;
                REG_GRN_INT:    r_cfg.grn_int    <= i_cfg_data;
                REG_GRN_HUE_HI: r_cfg.grn_hue_hi <= i_cfg_data;
                REG_SELECT:     r_cfg.sel        <= i_cfg_data[1:0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    assign en = !cls.valid || cls.ready;
    assign pix.ready = en;

    // stage 0: sums, min, initial vector
    logic        r_v0;
    t_vec        r_x0, r_y0;
    logic [15:0] r_z0;
    t_side       r_s0;
    logic [7:0]  mn;
    logic [9:0]  sum;
    logic signed [10:0] dx;
    logic signed [9:0]  dy;
    t_vec        x0, y0;

    always_comb begin
        mn = pix.red;
        if (pix.green < mn) mn = pix.green;
        if (pix.blue < mn) mn = pix.blue;
        sum = 10'(pix.red) + 10'(pix.green) + 10'(pix.blue);
        dx = 11'(2 * 11'(pix.red)) - 11'(pix.green) - 11'(pix.blue);
        dy = 10'(pix.green) - 10'(pix.blue);
        x0 = XW'(dx) <<< 16;
        y0 = XW'(dy) * XW'(SQRT3_Q16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0.sum    <= sum;
            r_s0.chroma <= sum - 10'(3 * 10'(mn));
            if (dx < 0) begin
                r_x0 <= -x0;
                r_y0 <= -y0;
                r_z0 <= 16'd32768;
            end else begin
                r_x0 <= x0;
                r_y0 <= y0;
                r_z0 <= 16'd0;
            end
        end
    end

    logic        v  [CORDIC_STEPS+1];
    t_vec        xx [CORDIC_STEPS+1];
    t_vec        yy [CORDIC_STEPS+1];
    logic [15:0] zz [CORDIC_STEPS+1];
    t_side       ss [CORDIC_STEPS+1];

    assign v[0]  = r_v0;
    assign xx[0] = r_x0;
    assign yy[0] = r_y0;
    assign zz[0] = r_z0;
    assign ss[0] = r_s0;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        htcc_cordic_stage #(.STEP(g)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v[g]),
            .i_x     (xx[g]),
            .i_y     (yy[g]),
            .i_z     (zz[g]),
            .i_side  (ss[g]),
            .o_valid (v[g+1]),
            .o_x     (xx[g+1]),
            .o_y     (yy[g+1]),
            .o_z     (zz[g+1]),
            .o_side  (ss[g+1])
        );
    end

    logic [15:0] hue;
    assign hue = (ss[CORDIC_STEPS].chroma == 10'd0) ? 16'd0 : zz[CORDIC_STEPS];

    htcc_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v[CORDIC_STEPS]),
        .i_hue   (hue),
        .i_side  (ss[CORDIC_STEPS]),
        .i_cfg   (r_cfg),
        .o_valid (cls.valid),
        .o_class (cls.color_class),
        .o_mask  (cls.mask_value)
    );

`ifndef SYNTH
    a_mask_only_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cls.valid |-> (cls.mask_value == 8'd0 || cls.mask_value == 8'd255))
        else $error("mask value not 0 or 255");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cls.valid && !cls.ready) |=> (cls.valid && $stable(cls.color_class)))
        else $error("result changed under stall");
    a_ready_on_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !cls.valid |-> pix.ready)
        else $error("request blocked with empty output");
`endif
endmodule

// File: tb/sv/hsi_traffic_color_classifier_test.sv
// Testbench: random and directed pixel checks of the HSI traffic color classifier.
`timescale 1ns / 100ps

module hsi_traffic_color_classifier_test;
    import htcc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct {
        t_class     cls;
        logic [7:0] mask;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [6:0] i_cfg_data;

    htcc_pix_if pix();
    htcc_cls_if cls();

    hsi_traffic_color_classifier dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .pix        (pix),
        .cls        (cls),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    t_pixel   pixel_q[$];
    t_verdict verdict_q[$];
    logic [6:0] thresholds[NUM_REGS];
    int  mismatches = 0;
    int  cycles = 0;
    bit  hold_off = 1'b0;
    int  burst_left = 0;
    int  gap_left = 0;
    logic [15:0] stall_pat = 16'hFFFF;
    int  stall_cnt = 0;

    const int unsigned atan_lut[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                        41, 20, 10, 5, 3, 1, 1, 0};

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int unsigned hue_turns(longint r, longint g, longint b);
        longint x, y, xs, ys;
        int unsigned z;
        x = (2 * r - g - b) * 65536;
        y = (g - b) * SQRT3_Q16;
        z = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32768;
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_lut[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_lut[i];
            end
        end
        return z & 32'hFFFF;
    endfunction

    function automatic t_verdict classify(t_pixel p);
        t_verdict v;
        longint sum, mn, chroma, h;
        bit sat_ok, int_ok;
        sum = p.red + p.green + p.blue;
        mn = p.red;
        if (p.green < mn) mn = p.green;
        if (p.blue < mn) mn = p.blue;
        chroma = sum - 3 * mn;
        h = (chroma != 0) ? hue_turns(p.red, p.green, p.blue) : 0;
        v.cls = CLS_NONE;
        if ((h * 100 >= 90 * 65536 || h * 100 <= 7 * 65536) &&
            100 * chroma > thresholds[REG_RED_SAT] * sum &&
            100 * sum > 765 * thresholds[REG_RED_INT]) begin
            v.cls = CLS_RED;
        end else if (h * 100 >= 7 * 65536 && h * 100 <= 15 * 65536 &&
            100 * chroma > thresholds[REG_YEL_SAT] * sum &&
            100 * sum > 765 * thresholds[REG_YEL_INT]) begin
            v.cls = CLS_YELLOW;
        end else if (h * 100 >= 40 * 65536 &&
            h * 100 <= longint'(thresholds[REG_GRN_HUE_HI]) * 65536 &&
            100 * chroma > thresholds[REG_GRN_SAT] * sum &&
            100 * sum > 765 * thresholds[REG_GRN_INT]) begin
            v.cls = CLS_GREEN;
        end
        v.mask = (v.cls == t_class'(thresholds[REG_SELECT][1:0])) ? 8'd255 : 8'd0;
        return v;
    endfunction

    // drive requests in bursts with gaps
    always @(posedge i_clk) begin
        t_pixel p;
        if (!i_rst_n) begin
            pix.valid <= 1'b0;
        end else if (!pix.valid || pix.ready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                pix.valid <= 1'b0;
            end else if (pixel_q.size() > 0 && !hold_off) begin
                p = pixel_q.pop_front();
                pix.red <= p.red;
                pix.green <= p.green;
                pix.blue <= p.blue;
                pix.valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                pix.valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (stall_cnt % 64 == 0)
            stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        stall_cnt <= stall_cnt + 1;
        cls.ready <= i_rst_n && stall_pat[stall_cnt % 16];
    end

    always @(posedge i_clk) begin
        t_pixel p;
        t_verdict v;
        if (i_rst_n && pix.valid && pix.ready) begin
            p.red = pix.red;
            p.green = pix.green;
            p.blue = pix.blue;
            verdict_q.insert(verdict_q.size(), classify(p));
        end
        if (i_rst_n && cls.valid && cls.ready) begin
            if (verdict_q.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result: class %0d mask %0d",
                             cls.color_class, cls.mask_value);
            end else begin
                v = verdict_q.pop_front();
                if (cls.color_class !== v.cls || cls.mask_value !== v.mask) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: class exp %0d got %0d, mask exp %0d got %0d",
                                 v.cls, cls.color_class, v.mask, cls.mask_value);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[hsi_traffic_color_classifier] ERROR");
            $finish;
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [6:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        thresholds[idx] = (idx == REG_SELECT) ? {5'd0, data[1:0]} : data;
    endtask

    task automatic write_all(logic [6:0] vals[NUM_REGS]);
        for (int k = 0; k < NUM_REGS; k++)
            write_reg(t_reg_idx'(k), vals[k]);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        wait (pixel_q.size() == 0 && verdict_q.size() == 0 && !pix.valid);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_pixel(int r, int g, int b);
        t_pixel p;
        p.red = 8'(r);
        p.green = 8'(g);
        p.blue = 8'(b);
        pixel_q.insert(pixel_q.size(), p);
    endtask

    task automatic push_random(int count);
        int hi, lo, mid, sel;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 3) == 0) begin
                push_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255));
            end else begin
                hi = $urandom_range(0, 255);
                lo = $urandom_range(0, hi);
                mid = $urandom_range(lo, hi);
                sel = $urandom_range(0, 5);
                case (sel)
                    0: push_pixel(hi, mid, lo);
                    1: push_pixel(hi, lo, mid);
                    2: push_pixel(mid, hi, lo);
                    3: push_pixel(lo, hi, mid);
                    4: push_pixel(mid, lo, hi);
                    default: push_pixel(lo, mid, hi);
                endcase
            end
        end
    endtask

    initial begin
        logic [6:0] vals[NUM_REGS];
        pix.valid = 1'b0;
        pix.red = 8'd0;
        pix.green = 8'd0;
        pix.blue = 8'd0;
        cls.ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = 3'd0;
        i_cfg_data = 7'd0;
        i_rst_n = 1'b0;
        thresholds = '{7'd27, 7'd19, 7'd35, 7'd35, 7'd24, 7'd11, 7'd55, 7'd0};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_pixel(0, 0, 0);
        push_pixel(255, 255, 255);
        push_pixel(128, 128, 128);
        push_pixel(255, 0, 0);
        push_pixel(0, 255, 0);
        push_pixel(0, 0, 255);
        push_pixel(255, 255, 0);
        push_pixel(255, 128, 0);
        push_pixel(255, 80, 0);
        push_pixel(255, 0, 255);
        push_pixel(255, 0, 40);
        push_pixel(0, 255, 255);
        push_pixel(0, 255, 128);
        push_pixel(0, 0, 1);
        push_pixel(1, 0, 0);
        push_pixel(170, 85, 85);
        push_pixel(85, 170, 170);
        push_pixel(40, 200, 120);
        push_pixel(30, 60, 20);
        push_pixel(254, 253, 0);
        push_random(150);
        wait (pixel_q.size() < 60);
        hold_off = 1'b1;
        wait (verdict_q.size() == 0 && !pix.valid);
        hold_off = 1'b0;
        wait_idle();

        vals = '{7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd1};
        write_all(vals);
        push_pixel(0, 0, 0);
        push_pixel(1, 1, 0);
        push_random(150);
        wait_idle();

        vals = '{7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'h7F};
        write_all(vals);
        push_pixel(0, 0, 0);
        push_random(100);
        wait_idle();

        vals = '{7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd2};
        write_all(vals);
        push_random(80);
        wait_idle();

        for (int ph = 0; ph < 5; ph++) begin
            for (int k = 0; k < NUM_REGS; k++)
                vals[k] = (k == REG_GRN_HUE_HI) ? 7'($urandom_range(40, 110))
                                                : 7'($urandom_range(0, 60));
            vals[REG_SELECT] = 7'($urandom_range(0, 127));
            write_all(vals);
            push_random(90);
            wait_idle();
        end

        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("[hsi_traffic_color_classifier] OK");
        end else begin
            $display("[hsi_traffic_color_classifier] ERROR");
        end
        $finish;
    end
endmodule

// File: sim.f
hdl/htcc_pkg.sv
hdl/htcc_pix_if.sv
hdl/htcc_cordic_stage.sv
hdl/htcc_classify.sv
hdl/hsi_traffic_color_classifier.sv
tb/sv/hsi_traffic_color_classifier_test.sv
